// ===== rtl/sbvg_pkg.sv =====
// Shared types, constants and tables for the sphere band vertex generator.
`timescale 1ns / 1ps

package sbvg_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RADIUS   = 2'd0,
        CFG_LAT_SEGS = 2'd1,
        CFG_LNG_SEGS = 2'd2,
        CFG_UNUSED   = 2'd3
    } cfg_index_t;

    // Angle divider: numerator bits, divisor bits, kept quotient bits
    localparam int DIV_NW = 27;
    localparam int DIV_DW = 9;
    localparam int DIV_QW = 16;

    // CORDIC datapath widths (Q2.30 vectors, turn-scaled angle)
    localparam int CRD_XW = 33;
    localparam int CRD_ZW = 34;
    localparam logic signed [CRD_XW-1:0] CORDIC_K_Q30 = 33'sd652032874;

    // Result range, signed Q8.8
    localparam int OUT_W = 17;

    typedef logic signed [15:0] q15_t;
    typedef logic signed [OUT_W-1:0] coord_t;

    // atan(2^-k) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

// ===== rtl/sbvg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, low quotient bits kept.
`timescale 1ns / 1ps

module sbvg_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [sbvg_pkg::DIV_NW-1:0]   in_num,
    input  logic [sbvg_pkg::DIV_DW-1:0]   divisor,
    output logic                          out_valid,
    output logic [sbvg_pkg::DIV_QW-1:0]   out_quo
);
    import sbvg_pkg::*;

    logic [DIV_DW-1:0] rem_w [DIV_NW+1];
    logic [DIV_NW-1:0] num_w [DIV_NW+1];
    logic [DIV_QW-1:0] quo_w [DIV_NW+1];
    logic              vld_w [DIV_NW+1];

    assign rem_w[0] = '0;
    assign num_w[0] = in_num;
    assign quo_w[0] = '0;
    assign vld_w[0] = in_valid;

    // one shift-compare-subtract per stage
    for (genvar s = 0; s < DIV_NW; s++) begin : g_stage
        logic [DIV_DW:0]   trial;
        logic              ge;
        logic [DIV_DW-1:0] rem_reg;
        logic [DIV_NW-1:0] num_reg;
        logic [DIV_QW-1:0] quo_reg;
        logic              vld_reg;

        assign trial = {rem_w[s], num_w[s][DIV_NW-1]};
        assign ge    = (trial >= {1'b0, divisor});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= vld_w[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg <= ge ? DIV_DW'(trial - {1'b0, divisor}) : trial[DIV_DW-1:0];
                num_reg <= {num_w[s][DIV_NW-2:0], 1'b0};
                quo_reg <= {quo_w[s][DIV_QW-2:0], ge};
            end
        end

        assign rem_w[s+1] = rem_reg;
        assign num_w[s+1] = num_reg;
        assign quo_w[s+1] = quo_reg;
        assign vld_w[s+1] = vld_reg;
    end

    assign out_valid = vld_w[DIV_NW];
    assign out_quo   = quo_w[DIV_NW];

endmodule

// ===== rtl/sbvg_cordic.sv =====
// Pipelined rotation-mode CORDIC: sine and cosine of a Q0.16 turn angle in Q1.15.
`timescale 1ns / 1ps

module sbvg_cordic #(
    parameter int STAGES = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [15:0]      in_angle,
    output logic             out_valid,
    output sbvg_pkg::q15_t   out_sin,
    output sbvg_pkg::q15_t   out_cos
);
    import sbvg_pkg::*;

    logic signed [CRD_XW-1:0] x_w [STAGES+1];
    logic signed [CRD_XW-1:0] y_w [STAGES+1];
    logic signed [CRD_ZW-1:0] z_w [STAGES+1];
    logic                     flip_w [STAGES+1];
    logic                     vld_w  [STAGES+1];

    // front stage: fold the far half turn onto the near one
    logic [15:0] quarter_sum;
    logic        flip;
    logic [15:0] folded;
    logic signed [CRD_XW-1:0] x0_reg, y0_reg;
    logic signed [CRD_ZW-1:0] z0_reg;
    logic                     flip0_reg, vld0_reg;

    assign quarter_sum = in_angle + 16'd16384;
    assign flip        = quarter_sum[15];
    assign folded      = flip ? (in_angle ^ 16'h8000) : in_angle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
        end else if (en) begin
            vld0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg    <= CORDIC_K_Q30;
            y0_reg    <= '0;
            z0_reg    <= {{2{folded[15]}}, folded, 16'd0};
            flip0_reg <= flip;
        end
    end

    assign x_w[0]    = x0_reg;
    assign y_w[0]    = y0_reg;
    assign z_w[0]    = z0_reg;
    assign flip_w[0] = flip0_reg;
    assign vld_w[0]  = vld0_reg;

    // micro-rotations
    for (genvar k = 0; k < STAGES; k++) begin : g_iter
        logic signed [CRD_XW-1:0] dx, dy;
        logic signed [CRD_ZW-1:0] da;
        logic signed [CRD_XW-1:0] x_reg, y_reg;
        logic signed [CRD_ZW-1:0] z_reg;
        logic                     flip_reg, vld_reg;

        assign dx = y_w[k] >>> k;
        assign dy = x_w[k] >>> k;
        assign da = $signed({2'b00, ATAN_TURNS[k]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= vld_w[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_w[k][CRD_ZW-1]) begin
                    x_reg <= x_w[k] - dx;
                    y_reg <= y_w[k] + dy;
                    z_reg <= z_w[k] - da;
                end else begin
                    x_reg <= x_w[k] + dx;
                    y_reg <= y_w[k] - dy;
                    z_reg <= z_w[k] + da;
                end
                flip_reg <= flip_w[k];
            end
        end

        assign x_w[k+1]    = x_reg;
        assign y_w[k+1]    = y_reg;
        assign z_w[k+1]    = z_reg;
        assign flip_w[k+1] = flip_reg;
        assign vld_w[k+1]  = vld_reg;
    end

    // back stage: round to Q1.15, undo the fold, saturate
    logic signed [CRD_XW-1:0] x_rnd, y_rnd;
    logic signed [18:0]       x_s, y_s, x_f, y_f;
    q15_t                     cos_reg, sin_reg;
    logic                     vld_out_reg;

    assign x_rnd = x_w[STAGES] + 33'sd16384;
    assign y_rnd = y_w[STAGES] + 33'sd16384;
    assign x_s   = 19'(x_rnd >>> 15);
    assign y_s   = 19'(y_rnd >>> 15);
    assign x_f   = flip_w[STAGES] ? -x_s : x_s;
    assign y_f   = flip_w[STAGES] ? -y_s : y_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_out_reg <= 1'b0;
        end else if (en) begin
            vld_out_reg <= vld_w[STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= (x_f > 19'sd32767) ? 16'sh7FFF :
                       (x_f < -19'sd32768) ? 16'sh8000 : x_f[15:0];
            sin_reg <= (y_f > 19'sd32767) ? 16'sh7FFF :
                       (y_f < -19'sd32768) ? 16'sh8000 : y_f[15:0];
        end
    end

    assign out_valid = vld_out_reg;
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;

endmodule

// ===== rtl/sbvg_scale.sv =====
// Three-stage vertex scaler: trig products times radius, rounded and saturated to Q8.8.
`timescale 1ns / 1ps

module sbvg_scale (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  sbvg_pkg::q15_t     lng_cos,
    input  sbvg_pkg::q15_t     lng_sin,
    input  sbvg_pkg::q15_t     lat_cos,
    input  sbvg_pkg::q15_t     lat_sin,
    input  logic [15:0]        radius,
    output logic               out_valid,
    output sbvg_pkg::coord_t   out_x,
    output sbvg_pkg::coord_t   out_y,
    output sbvg_pkg::coord_t   out_z
);
    import sbvg_pkg::*;

    logic signed [16:0] r_s;
    assign r_s = $signed({1'b0, radius});

    // stage 1: longitude trig times cos(lat), sin(lat) times radius
    logic signed [31:0] pc_reg, ps_reg;
    logic signed [32:0] zr1_reg;
    logic               v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pc_reg  <= lng_cos * lat_cos;
            ps_reg  <= lng_sin * lat_cos;
            zr1_reg <= lat_sin * r_s;
        end
    end

    // stage 2: horizontal products times radius
    logic signed [48:0] px_reg, py_reg;
    logic signed [32:0] zr2_reg;
    logic               v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg  <= pc_reg * r_s;
            py_reg  <= ps_reg * r_s;
            zr2_reg <= zr1_reg;
        end
    end

    // stage 3: round half up, shift, saturate
    logic signed [48:0] px_rnd, py_rnd;
    logic signed [32:0] z_rnd;
    logic signed [18:0] x_s, y_s;
    logic signed [17:0] z_s;
    coord_t             x_reg, y_reg, z_reg;
    logic               v3_reg;

    assign px_rnd = px_reg + 49'sd536870912;
    assign py_rnd = py_reg + 49'sd536870912;
    assign z_rnd  = zr2_reg + 33'sd16384;
    assign x_s    = 19'(px_rnd >>> 30);
    assign y_s    = 19'(py_rnd >>> 30);
    assign z_s    = 18'(z_rnd >>> 15);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= (x_s > 19'sd65535) ? 17'sh0FFFF :
                     (x_s < -19'sd65536) ? 17'sh10000 : x_s[16:0];
            y_reg <= (y_s > 19'sd65535) ? 17'sh0FFFF :
                     (y_s < -19'sd65536) ? 17'sh10000 : y_s[16:0];
            z_reg <= (z_s > 18'sd65535) ? 17'sh0FFFF :
                     (z_s < -18'sd65536) ? 17'sh10000 : z_s[16:0];
        end
    end

    assign out_valid = v3_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

// ===== rtl/sphere_band_vertex_generator.sv =====
// Top level: UV sphere band vertex generator, angle dividers, CORDICs and scalers.
//
//  channel  ports                          beat
//  -------  -----------------------------  ------------------------------------
//  input    s_valid/s_ready, s_*_index     one (ring, column) index pair
//  output   m_valid/m_ready, m_lower_*,    lower and upper vertex, signed Q8.8
//           m_upper_*
//  config   cfg_wr_en, cfg_index, cfg_wdata register write, no handshake
//
// One beat enters per cycle while the output beat is not blocked; the pipeline is 27 divider
// stages, CORDIC_STAGES + 2 CORDIC stages and 3 scaler stages, set by the
// bit-per-stage angle dividers and the CORDIC rotation chain.
// Reset clears all valid bits and loads radius 1.0 and 10 by 10 segments.
// When the output beat is not taken the whole pipeline holds; nothing is lost.
`timescale 1ns / 1ps

module sphere_band_vertex_generator #(
    parameter int INDEX_BITS    = 8,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_ring_index,
    input  logic [7:0]              s_column_index,
    output logic                    m_valid,
    input  logic                    m_ready,
    output sbvg_pkg::coord_t        m_lower_x,
    output sbvg_pkg::coord_t        m_lower_y,
    output sbvg_pkg::coord_t        m_lower_z,
    output sbvg_pkg::coord_t        m_upper_x,
    output sbvg_pkg::coord_t        m_upper_y,
    output sbvg_pkg::coord_t        m_upper_z
);
    import sbvg_pkg::*;

    localparam logic [7:0] IDX_MASK =
        (INDEX_BITS >= 8) ? 8'hFF : 8'((1 << INDEX_BITS) - 1);

    // configuration registers
    logic [15:0] radius_reg;
    logic [7:0]  lat_segs_reg, lng_segs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= 16'd256;
            lat_segs_reg <= 8'd10;
            lng_segs_reg <= 8'd10;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RADIUS:   radius_reg   <= cfg_wdata;
                CFG_LAT_SEGS: lat_segs_reg <= cfg_wdata[7:0];
                CFG_LNG_SEGS: lng_segs_reg <= cfg_wdata[7:0];
                default:      ;
            endcase
        end
    end

    // global advance: pipeline moves unless a finished beat is blocked
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // angle numerators: index (lower ring, column one step back) over 2*lat or lng count
    logic [7:0]        h, v, ri, ci;
    logic [DIV_DW-1:0] h2, v2;
    logic [9:0]        k_lo, k_hi, k_lng;
    logic [DIV_NW-1:0] num_lo, num_hi, num_lng;
    logic              in_beat;

    assign h       = (lat_segs_reg == 8'd0) ? 8'd1 : lat_segs_reg;
    assign v       = (lng_segs_reg == 8'd0) ? 8'd1 : lng_segs_reg;
    assign h2      = {h, 1'b0};
    assign v2      = {v, 1'b0};
    assign ri      = s_ring_index & IDX_MASK;
    assign ci      = s_column_index & IDX_MASK;
    assign k_lo    = 10'(ri) + 10'(h2) - 10'd1;
    assign k_hi    = 10'(ri);
    assign k_lng   = 10'(ci) + 10'(v) - 10'd1;
    assign num_lo  = DIV_NW'({k_lo, 16'd0}) + DIV_NW'(h);
    assign num_hi  = DIV_NW'({k_hi, 16'd0}) + DIV_NW'(h);
    assign num_lng = {k_lng, 17'd0} + DIV_NW'(v);
    assign in_beat = s_valid && s_ready;

    logic              div_valid;
    logic [DIV_QW-1:0] q_lo, q_hi, q_lng;

    sbvg_div u_div_lo (
        .aclk, .aresetn, .en,
        .in_valid (in_beat), .in_num (num_lo), .divisor (h2),
        .out_valid (div_valid), .out_quo (q_lo)
    );

    sbvg_div u_div_hi (
        .aclk, .aresetn, .en,
        .in_valid (in_beat), .in_num (num_hi), .divisor (h2),
        .out_valid (), .out_quo (q_hi)
    );

    sbvg_div u_div_lng (
        .aclk, .aresetn, .en,
        .in_valid (in_beat), .in_num (num_lng), .divisor (v2),
        .out_valid (), .out_quo (q_lng)
    );

    // latitude starts at the south pole
    logic [15:0] ang_lo, ang_hi;
    assign ang_lo = q_lo - 16'd16384;
    assign ang_hi = q_hi - 16'd16384;

    logic crd_valid;
    q15_t lo_sin, lo_cos, hi_sin, hi_cos, lng_sin, lng_cos;

    sbvg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lo (
        .aclk, .aresetn, .en,
        .in_valid (div_valid), .in_angle (ang_lo),
        .out_valid (crd_valid), .out_sin (lo_sin), .out_cos (lo_cos)
    );

    sbvg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_hi (
        .aclk, .aresetn, .en,
        .in_valid (div_valid), .in_angle (ang_hi),
        .out_valid (), .out_sin (hi_sin), .out_cos (hi_cos)
    );

    sbvg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lng (
        .aclk, .aresetn, .en,
        .in_valid (div_valid), .in_angle (q_lng),
        .out_valid (), .out_sin (lng_sin), .out_cos (lng_cos)
    );

    // vertex scaling; the lower scaler's output register carries the result valid
    sbvg_scale u_scale_lo (
        .aclk, .aresetn, .en,
        .in_valid (crd_valid),
        .lng_cos (lng_cos), .lng_sin (lng_sin),
        .lat_cos (lo_cos), .lat_sin (lo_sin),
        .radius (radius_reg),
        .out_valid (m_valid),
        .out_x (m_lower_x), .out_y (m_lower_y), .out_z (m_lower_z)
    );

    sbvg_scale u_scale_hi (
        .aclk, .aresetn, .en,
        .in_valid (crd_valid),
        .lng_cos (lng_cos), .lng_sin (lng_sin),
        .lat_cos (hi_cos), .lat_sin (hi_sin),
        .radius (radius_reg),
        .out_valid (),
        .out_x (m_upper_x), .out_y (m_upper_y), .out_z (m_upper_z)
    );

endmodule
